FILE: hw/rtl/stt_pkg.sv
package stt_pkg;

    // table geometry
    localparam int SLOTS       = 16;
    localparam int MAX_RESULTS = 16;
    localparam int IDX_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int NF_W        = $clog2(MAX_RESULTS + 1);

    // field widths
    localparam int CMD_W  = 2;
    localparam int SLOT_W = 7;
    localparam int TICK_W = 32;
    localparam int KIND_W = 2;

    // command codes on the input port
    localparam logic [CMD_W-1:0] CMD_CREATE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DESTROY = 2'd1;
    localparam logic [CMD_W-1:0] CMD_UPDATE  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_TICK    = 2'd3;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_CREATED = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FULL    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FIRED   = 2'd2;

    // decoded operation carried through the queue
    typedef enum logic [1:0] {
        OP_CREATE  = 2'd0,
        OP_DESTROY = 2'd1,
        OP_UPDATE  = 2'd2,
        OP_TICK    = 2'd3
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [IDX_W-1:0]  idx;
        logic [TICK_W-1:0] now;
        logic [TICK_W-1:0] delay;
        logic [TICK_W-1:0] interval;
        logic              repeat_req;
        logic [TICK_W-1:0] param;
    } t_item;

    // queue head as seen by the back end
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_q_head;

endpackage

FILE: hw/rtl/stt_front.sv
module stt_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [stt_pkg::CMD_W-1:0]    i_command,
    input  logic [stt_pkg::TICK_W-1:0]   i_now_tick,
    input  logic [stt_pkg::SLOT_W-1:0]   i_slot_id,
    input  logic [stt_pkg::TICK_W-1:0]   i_delay,
    input  logic [stt_pkg::TICK_W-1:0]   i_interval,
    input  logic                         i_repeat_req,
    input  logic [stt_pkg::TICK_W-1:0]   i_user_param,
    input  logic                         i_pop,
    output stt_pkg::t_q_head             o_head
);
    import stt_pkg::*;

    localparam int QDEPTH = 2;

    t_item      r_q [QDEPTH];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;

    t_item      w_item;
    logic       w_id_ok;
    logic       w_keep;
    logic       w_accept;
    logic       w_push;
    logic       w_pop;
    logic [SLOT_W-1:0] w_id_m1;

    // classify the incoming command
    always_comb begin
        w_id_ok = i_slot_id inside {[SLOT_W'(1):SLOT_W'(SLOTS)]};
        w_id_m1 = i_slot_id - SLOT_W'(1);
        w_item.idx        = w_id_m1[IDX_W-1:0];
        w_item.now        = i_now_tick;
        w_item.delay      = i_delay;
        w_item.interval   = i_interval;
        w_item.repeat_req = i_repeat_req;
        w_item.param      = i_user_param;
        case (i_command)
            CMD_CREATE: begin
                w_item.op = OP_CREATE;
                w_keep    = 1'b1;
            end
            CMD_DESTROY: begin
                w_item.op = OP_DESTROY;
                w_keep    = w_id_ok;
            end
            CMD_UPDATE: begin
                w_item.op = OP_UPDATE;
                w_keep    = w_id_ok;
            end
            default: begin
                w_item.op = OP_TICK;
                w_keep    = 1'b1;
            end
        endcase
    end

    // queue bookkeeping; destroy and update of a bad slot number are dropped here
    assign busy     = (r_count == 2'(QDEPTH));
    assign w_accept = start && !busy;
    assign w_push   = w_accept && w_keep;
    assign w_pop    = i_pop && (r_count != 2'd0);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = ~r_wr_ptr;
        end
        if (w_pop) begin
            n_rd_ptr = ~r_rd_ptr;
        end
        case ({w_push, w_pop})
            2'b10:   n_count = r_count + 2'd1;
            2'b01:   n_count = r_count - 2'd1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_item;
        end
    end

    assign o_head.valid = (r_count != 2'd0);
    assign o_head.item  = r_q[r_rd_ptr];

    // queue never overflows or underflows
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'(QDEPTH))
        else $error("queue count out of range");

    a_full_no_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'(QDEPTH)) && !w_pop |=> (r_count == 2'(QDEPTH)))
        else $error("full queue changed without a pop");

    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd1) |-> (r_wr_ptr != r_rd_ptr))
        else $error("pointers disagree with count");

endmodule

FILE: hw/rtl/stt_back.sv
module stt_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  stt_pkg::t_q_head             i_head,
    output logic                         o_pop,
    output logic                         o_strobe,
    output logic [stt_pkg::KIND_W-1:0]   o_kind,
    output logic [stt_pkg::SLOT_W-1:0]   o_fired_slot,
    output logic [stt_pkg::TICK_W-1:0]   o_param_out,
    output logic                         o_slot_freed,
    output logic                         o_last_of_run
);
    import stt_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_CREATE = 6'b000010,
        ST_UPD_RD = 6'b000100,
        ST_UPD_WR = 6'b001000,
        ST_SWEEP  = 6'b010000,
        ST_FLUSH  = 6'b100000
    } t_state;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    // slot storage
    logic [TICK_W-1:0] r_mem_param    [SLOTS];
    logic [TICK_W-1:0] r_mem_delay    [SLOTS];
    logic [TICK_W-1:0] r_mem_interval [SLOTS];
    logic [TICK_W-1:0] r_mem_start    [SLOTS];
    logic              r_mem_repeats  [SLOTS];

    logic [TICK_W-1:0] r_rd_param, r_rd_delay, r_rd_interval, r_rd_start;
    logic              r_rd_repeats;

    // control state
    t_state            r_state, n_state;
    logic [SLOTS-1:0]  r_active, n_active;
    t_item             r_cur, n_cur;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic              r_issue_done, n_issue_done;
    logic              r_ev_valid, n_ev_valid;
    logic [IDX_W-1:0]  r_ev_idx, n_ev_idx;
    logic [NF_W-1:0]   r_nfired, n_nfired;

    // held fired result, sent once the next one or the end of sweep is known
    logic              r_pend_valid, n_pend_valid;
    logic [IDX_W-1:0]  r_pend_idx, n_pend_idx;
    logic [TICK_W-1:0] r_pend_param, n_pend_param;
    logic              r_pend_freed, n_pend_freed;

    // output register
    logic              r_out_strobe, n_out_strobe;
    logic [KIND_W-1:0] r_out_kind, n_out_kind;
    logic [SLOT_W-1:0] r_out_slot, n_out_slot;
    logic [TICK_W-1:0] r_out_param, n_out_param;
    logic              r_out_freed, n_out_freed;
    logic              r_out_last, n_out_last;

    // memory ports
    logic [IDX_W-1:0]  w_raddr;
    logic              w_param_we, w_delay_we, w_ivl_we, w_start_we, w_rep_we;
    logic [IDX_W-1:0]  w_param_wa, w_delay_wa, w_ivl_wa, w_start_wa, w_rep_wa;
    logic [TICK_W-1:0] w_param_wd, w_delay_wd, w_ivl_wd, w_start_wd;
    logic              w_rep_wd;

    logic [TICK_W-1:0] w_elapsed;
    logic              w_due;

    assign w_elapsed = r_cur.now - r_rd_start;
    assign w_due     = r_active[r_ev_idx] && (w_elapsed >= r_rd_delay)
                       && (r_nfired < NF_W'(MAX_RESULTS));
    assign o_pop     = (r_state == ST_IDLE) && i_head.valid;

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_active     = r_active;
        n_cur        = r_cur;
        n_idx        = r_idx;
        n_issue_done = r_issue_done;
        n_ev_valid   = 1'b0;
        n_ev_idx     = r_ev_idx;
        n_nfired     = r_nfired;
        n_pend_valid = r_pend_valid;
        n_pend_idx   = r_pend_idx;
        n_pend_param = r_pend_param;
        n_pend_freed = r_pend_freed;
        n_out_strobe = 1'b0;
        n_out_kind   = r_out_kind;
        n_out_slot   = r_out_slot;
        n_out_param  = r_out_param;
        n_out_freed  = r_out_freed;
        n_out_last   = r_out_last;

        w_raddr    = r_cur.idx;
        w_param_we = 1'b0;
        w_param_wa = r_idx;
        w_param_wd = r_cur.param;
        w_delay_we = 1'b0;
        w_delay_wa = r_idx;
        w_delay_wd = r_cur.delay;
        w_ivl_we   = 1'b0;
        w_ivl_wa   = r_idx;
        w_ivl_wd   = r_cur.interval;
        w_start_we = 1'b0;
        w_start_wa = r_idx;
        w_start_wd = r_cur.now;
        w_rep_we   = 1'b0;
        w_rep_wa   = r_idx;
        w_rep_wd   = r_cur.repeat_req;

        case (r_state)
            ST_IDLE: begin
                if (i_head.valid) begin
                    n_cur        = i_head.item;
                    n_idx        = '0;
                    n_issue_done = 1'b0;
                    n_nfired     = '0;
                    n_pend_valid = 1'b0;
                    case (i_head.item.op)
                        OP_CREATE:  n_state = ST_CREATE;
                        OP_DESTROY: n_active[i_head.item.idx] = 1'b0;
                        OP_UPDATE:  n_state = ST_UPD_RD;
                        default:    n_state = ST_SWEEP;
                    endcase
                end
            end

            // look for the lowest free slot, one per cycle
            ST_CREATE: begin
                if (!r_active[r_idx]) begin
                    n_active[r_idx] = 1'b1;
                    w_param_we   = 1'b1;
                    w_delay_we   = 1'b1;
                    w_ivl_we     = 1'b1;
                    w_start_we   = 1'b1;
                    w_rep_we     = 1'b1;
                    n_out_strobe = 1'b1;
                    n_out_kind   = KIND_CREATED;
                    n_out_slot   = SLOT_W'(r_idx) + SLOT_W'(1);
                    n_out_param  = '0;
                    n_out_freed  = 1'b0;
                    n_out_last   = 1'b1;
                    n_state      = ST_IDLE;
                end else if (r_idx == LAST_IDX) begin
                    n_out_strobe = 1'b1;
                    n_out_kind   = KIND_FULL;
                    n_out_slot   = '0;
                    n_out_param  = '0;
                    n_out_freed  = 1'b0;
                    n_out_last   = 1'b1;
                    n_state      = ST_IDLE;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end

            // repeat flag read happens here, writes follow
            ST_UPD_RD: begin
                n_state = ST_UPD_WR;
            end

            ST_UPD_WR: begin
                w_param_we = 1'b1;
                w_param_wa = r_cur.idx;
                w_delay_we = 1'b1;
                w_delay_wa = r_cur.idx;
                w_ivl_we   = r_rd_repeats;
                w_ivl_wa   = r_cur.idx;
                w_ivl_wd   = r_cur.delay;
                n_state    = ST_IDLE;
            end

            // read slot k while slot k-1 is evaluated
            ST_SWEEP: begin
                w_raddr = r_idx;
                if (!r_issue_done) begin
                    n_ev_valid = 1'b1;
                    n_ev_idx   = r_idx;
                    if (r_idx == LAST_IDX) begin
                        n_issue_done = 1'b1;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
                if (r_ev_valid) begin
                    if (w_due) begin
                        w_start_we = 1'b1;
                        w_start_wa = r_ev_idx;
                        w_delay_we = r_rd_repeats;
                        w_delay_wa = r_ev_idx;
                        w_delay_wd = r_rd_interval;
                        if (!r_rd_repeats) begin
                            n_active[r_ev_idx] = 1'b0;
                        end
                        n_nfired = r_nfired + NF_W'(1);
                        if (r_pend_valid) begin
                            n_out_strobe = 1'b1;
                            n_out_kind   = KIND_FIRED;
                            n_out_slot   = SLOT_W'(r_pend_idx) + SLOT_W'(1);
                            n_out_param  = r_pend_param;
                            n_out_freed  = r_pend_freed;
                            n_out_last   = 1'b0;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_idx   = r_ev_idx;
                        n_pend_param = r_rd_param;
                        n_pend_freed = !r_rd_repeats;
                    end
                    if (r_ev_idx == LAST_IDX) begin
                        n_state = ST_FLUSH;
                    end
                end
            end

            // last fired result of the sweep
            ST_FLUSH: begin
                if (r_pend_valid) begin
                    n_out_strobe = 1'b1;
                    n_out_kind   = KIND_FIRED;
                    n_out_slot   = SLOT_W'(r_pend_idx) + SLOT_W'(1);
                    n_out_param  = r_pend_param;
                    n_out_freed  = r_pend_freed;
                    n_out_last   = 1'b1;
                end
                n_pend_valid = 1'b0;
                n_state      = ST_IDLE;
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_active     <= '0;
            r_issue_done <= 1'b0;
            r_ev_valid   <= 1'b0;
            r_nfired     <= '0;
            r_pend_valid <= 1'b0;
            r_out_strobe <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_active     <= n_active;
            r_issue_done <= n_issue_done;
            r_ev_valid   <= n_ev_valid;
            r_nfired     <= n_nfired;
            r_pend_valid <= n_pend_valid;
            r_out_strobe <= n_out_strobe;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cur        <= n_cur;
        r_idx        <= n_idx;
        r_ev_idx     <= n_ev_idx;
        r_pend_idx   <= n_pend_idx;
        r_pend_param <= n_pend_param;
        r_pend_freed <= n_pend_freed;
        r_out_kind   <= n_out_kind;
        r_out_slot   <= n_out_slot;
        r_out_param  <= n_out_param;
        r_out_freed  <= n_out_freed;
        r_out_last   <= n_out_last;
    end

    // slot memories, one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (w_param_we) begin
            r_mem_param[w_param_wa] <= w_param_wd;
        end
        r_rd_param <= r_mem_param[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_delay_we) begin
            r_mem_delay[w_delay_wa] <= w_delay_wd;
        end
        r_rd_delay <= r_mem_delay[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_ivl_we) begin
            r_mem_interval[w_ivl_wa] <= w_ivl_wd;
        end
        r_rd_interval <= r_mem_interval[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_start_we) begin
            r_mem_start[w_start_wa] <= w_start_wd;
        end
        r_rd_start <= r_mem_start[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_rep_we) begin
            r_mem_repeats[w_rep_wa] <= w_rep_wd;
        end
        r_rd_repeats <= r_mem_repeats[w_raddr];
    end

    assign o_strobe      = r_out_strobe;
    assign o_kind        = r_out_kind;
    assign o_fired_slot  = r_out_slot;
    assign o_param_out   = r_out_param;
    assign o_slot_freed  = r_out_freed;
    assign o_last_of_run = r_out_last;

    // checks
    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("state register not one-hot");

    a_create_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_kind != KIND_FIRED) |-> o_last_of_run)
        else $error("create result not marked last");

    a_last_fire_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_kind == KIND_FIRED) && o_last_of_run |-> (r_state == ST_IDLE))
        else $error("last fired result while sweep still running");

    a_fire_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nfired <= NF_W'(MAX_RESULTS))
        else $error("fired count beyond result limit");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state != ST_IDLE) || !$past(i_head.item.op != OP_DESTROY))
        else $error("non-destroy command left sequencer idle");

endmodule

FILE: hw/rtl/software_timer_table_core.sv
// Timer table with SLOTS slots (16). A command is taken when start is high and
// busy is low; commands wait in a two-entry queue ahead of the executing
// sequencer, so busy rises only when that queue is full. Create scans the
// active flags one slot per cycle; destroy clears the slot's active flag
// straight from idle; update reads its repeat flag from slot memory first and
// then writes the slot; a tick sweep reads one slot per cycle from the slot
// memories with the compare in the cycle after each read. Results appear on
// the o_ result ports for exactly one cycle with o_strobe high; they cannot be
// held off, so the receiver must take every strobe. A create result appears in
// the cycle after its slot is found. A fired result is held until the next
// slot fires or the sweep ends, and o_last_of_run marks the final result of
// each command.
module software_timer_table_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [stt_pkg::CMD_W-1:0]    i_command,
    input  logic [stt_pkg::TICK_W-1:0]   i_now_tick,
    input  logic [stt_pkg::SLOT_W-1:0]   i_slot_id,
    input  logic [stt_pkg::TICK_W-1:0]   i_delay,
    input  logic [stt_pkg::TICK_W-1:0]   i_interval,
    input  logic                         i_repeat_req,
    input  logic [stt_pkg::TICK_W-1:0]   i_user_param,
    output logic                         o_strobe,
    output logic [stt_pkg::KIND_W-1:0]   o_kind,
    output logic [stt_pkg::SLOT_W-1:0]   o_fired_slot,
    output logic [stt_pkg::TICK_W-1:0]   o_param_out,
    output logic                         o_slot_freed,
    output logic                         o_last_of_run
);
    import stt_pkg::*;

    t_q_head w_head;
    logic    w_pop;

    // command intake and queue
    stt_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_command    (i_command),
        .i_now_tick   (i_now_tick),
        .i_slot_id    (i_slot_id),
        .i_delay      (i_delay),
        .i_interval   (i_interval),
        .i_repeat_req (i_repeat_req),
        .i_user_param (i_user_param),
        .i_pop        (w_pop),
        .o_head       (w_head)
    );

    // slot table and sequencer
    stt_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (w_head),
        .o_pop         (w_pop),
        .o_strobe      (o_strobe),
        .o_kind        (o_kind),
        .o_fired_slot  (o_fired_slot),
        .o_param_out   (o_param_out),
        .o_slot_freed  (o_slot_freed),
        .o_last_of_run (o_last_of_run)
    );

endmodule

FILE: tb/software_timer_table_core_tb.sv
`timescale 1ns / 1ps
module software_timer_table_core_tb;
    import stt_pkg::*;

    // one result of the block, as seen on the output ports
    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [SLOT_W-1:0] slot;
        logic [TICK_W-1:0] param;
        logic              freed;
        logic              last;
    } t_tmr_event;

    // one command; typed rows carry their single expected result
    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [TICK_W-1:0] now;
        logic [SLOT_W-1:0] id;
        logic [TICK_W-1:0] dly;
        logic [TICK_W-1:0] ivl;
        logic              rep;
        logic [TICK_W-1:0] prm;
        bit                typed;
        t_tmr_event        want;
    } t_timer_cmd;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [CMD_W-1:0]  i_command;
    logic [TICK_W-1:0] i_now_tick;
    logic [SLOT_W-1:0] i_slot_id;
    logic [TICK_W-1:0] i_delay;
    logic [TICK_W-1:0] i_interval;
    logic              i_repeat_req;
    logic [TICK_W-1:0] i_user_param;
    logic              o_strobe;
    logic [KIND_W-1:0] o_kind;
    logic [SLOT_W-1:0] o_fired_slot;
    logic [TICK_W-1:0] o_param_out;
    logic              o_slot_freed;
    logic              o_last_of_run;

    // shadow copy of the timer table
    bit                sl_active  [SLOTS];
    bit                sl_rep     [SLOTS];
    bit                sl_written [SLOTS];
    logic [TICK_W-1:0] sl_param   [SLOTS];
    logic [TICK_W-1:0] sl_delay   [SLOTS];
    logic [TICK_W-1:0] sl_ivl     [SLOTS];
    logic [TICK_W-1:0] sl_start   [SLOTS];

    t_tmr_event cmd_events[$];
    t_tmr_event awaited_events[$];
    t_tmr_event head_ev;
    int         err_cnt = 0;

    software_timer_table_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_command     (i_command),
        .i_now_tick    (i_now_tick),
        .i_slot_id     (i_slot_id),
        .i_delay       (i_delay),
        .i_interval    (i_interval),
        .i_repeat_req  (i_repeat_req),
        .i_user_param  (i_user_param),
        .o_strobe      (o_strobe),
        .o_kind        (o_kind),
        .o_fired_slot  (o_fired_slot),
        .o_param_out   (o_param_out),
        .o_slot_freed  (o_slot_freed),
        .o_last_of_run (o_last_of_run)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // hard stop in case the block hangs
    initial begin
        #5_000_000;
        $display("software_timer_table_core_tb: done, errors");
        $finish;
    end

    function automatic t_timer_cmd mk_cmd(input logic [CMD_W-1:0] cmd,
                                          input logic [TICK_W-1:0] now,
                                          input logic [SLOT_W-1:0] id,
                                          input logic [TICK_W-1:0] dly,
                                          input logic [TICK_W-1:0] ivl,
                                          input logic rep,
                                          input logic [TICK_W-1:0] prm);
        t_timer_cmd c;
        c.cmd   = cmd;
        c.now   = now;
        c.id    = id;
        c.dly   = dly;
        c.ivl   = ivl;
        c.rep   = rep;
        c.prm   = prm;
        c.typed = 1'b0;
        c.want  = '{default: '0};
        return c;
    endfunction

    function automatic t_timer_cmd with_result(input t_timer_cmd c,
                                               input logic [KIND_W-1:0] kind,
                                               input logic [SLOT_W-1:0] slot,
                                               input logic [TICK_W-1:0] param,
                                               input logic freed);
        c.typed      = 1'b1;
        c.want.kind  = kind;
        c.want.slot  = slot;
        c.want.param = param;
        c.want.freed = freed;
        c.want.last  = 1'b1;
        return c;
    endfunction

    // apply one command to the shadow table, leave its results in cmd_events
    function automatic void predict_cmd(input t_timer_cmd c);
        t_tmr_event        ev;
        logic [TICK_W-1:0] elapsed;
        int                idx;
        int                k;
        cmd_events.delete();
        ev      = '{default: '0};
        ev.last = 1'b1;
        if (c.cmd == CMD_CREATE) begin
            // lowest free slot wins
            idx = -1;
            for (k = SLOTS - 1; k >= 0; k--)
                if (!sl_active[k]) idx = k;
            if (idx < 0) begin
                ev.kind = KIND_FULL;
            end else begin
                sl_active[idx]  = 1'b1;
                sl_written[idx] = 1'b1;
                sl_param[idx]   = c.prm;
                sl_delay[idx]   = c.dly;
                sl_ivl[idx]     = c.ivl;
                sl_rep[idx]     = c.rep;
                sl_start[idx]   = c.now;
                ev.kind         = KIND_CREATED;
                ev.slot         = SLOT_W'(idx + 1);
            end
            cmd_events.push_back(ev);
        end else if (c.cmd == CMD_DESTROY || c.cmd == CMD_UPDATE) begin
            if (c.id != 0 && c.id <= SLOTS) begin
                idx = int'(c.id) - 1;
                if (c.cmd == CMD_DESTROY) begin
                    sl_active[idx] = 1'b0;
                end else begin
                    sl_param[idx] = c.prm;
                    sl_delay[idx] = c.dly;
                    if (sl_rep[idx]) sl_ivl[idx] = c.dly;
                end
            end
        end else begin
            // sweep in ascending order, wrap-around elapsed time
            for (k = 0; k < SLOTS && cmd_events.size() < MAX_RESULTS; k++) begin
                elapsed = c.now - sl_start[k];
                if (sl_active[k] && elapsed >= sl_delay[k]) begin
                    sl_start[k] = c.now;
                    ev.kind     = KIND_FIRED;
                    ev.slot     = SLOT_W'(k + 1);
                    ev.param    = sl_param[k];
                    ev.last     = 1'b0;
                    if (sl_rep[k]) begin
                        sl_delay[k] = sl_ivl[k];
                        ev.freed    = 1'b0;
                    end else begin
                        sl_active[k] = 1'b0;
                        ev.freed     = 1'b1;
                    end
                    cmd_events.push_back(ev);
                end
            end
            if (cmd_events.size() > 0) cmd_events[cmd_events.size() - 1].last = 1'b1;
        end
    endfunction

    // drive one command, after an idle gap if one is asked for, and wait for its transfer
    task automatic send_cmd(input t_timer_cmd c, input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_command    <= c.cmd;
        i_now_tick   <= c.now;
        i_slot_id    <= c.id;
        i_delay      <= c.dly;
        i_interval   <= c.ivl;
        i_repeat_req <= c.rep;
        i_user_param <= c.prm;
        do @(posedge i_clk); while (busy);
        predict_cmd(c);
        if (c.typed) begin
            awaited_events.push_back(c.want);
        end else begin
            foreach (cmd_events[i]) awaited_events.push_back(cmd_events[i]);
        end
    endtask

    function automatic void check_field(input string fname, input logic [TICK_W-1:0] want,
                                        input logic [TICK_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, fname, want, got);
            err_cnt++;
        end
    endfunction

    // result checker: every strobe is a transfer
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe === 1'b1) begin
            if (awaited_events.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual kind %0d slot %0d",
                         $time, o_kind, o_fired_slot);
                err_cnt++;
            end else begin
                head_ev = awaited_events.pop_front();
                check_field("kind", TICK_W'(head_ev.kind), TICK_W'(o_kind));
                check_field("fired_slot", TICK_W'(head_ev.slot), TICK_W'(o_fired_slot));
                check_field("param_out", head_ev.param, o_param_out);
                check_field("slot_freed", TICK_W'(head_ev.freed), TICK_W'(o_slot_freed));
                check_field("last_of_run", TICK_W'(head_ev.last), TICK_W'(o_last_of_run));
            end
        end
    end

    initial begin
        t_timer_cmd        c;
        t_timer_cmd        dir_rows[$];
        logic [TICK_W-1:0] tick_base;
        int                k;
        int                r;
        int                accepted;
        int                n_items;
        int                burst_left;
        bit                burst;
        bit                ignored;

        i_rst_n      <= 1'b0;
        start        <= 1'b0;
        i_command    <= CMD_TICK;
        i_now_tick   <= '0;
        i_slot_id    <= '0;
        i_delay      <= '0;
        i_interval   <= '0;
        i_repeat_req <= 1'b0;
        i_user_param <= '0;

        // directed table: one-shot at all-ones, wrap, ignored ids, free slots, full table
        dir_rows.push_back(with_result(mk_cmd(CMD_CREATE, '1, '0, '0, '0, 1'b0, '1),
                                       KIND_CREATED, 7'd1, '0, 1'b0));
        dir_rows.push_back(with_result(mk_cmd(CMD_TICK, '1, '0, '0, '0, 1'b0, '0),
                                       KIND_FIRED, 7'd1, '1, 1'b1));
        dir_rows.push_back(with_result(mk_cmd(CMD_CREATE, 32'hFFFF_FFFE, '0, 32'd5, 32'd3,
                                              1'b1, 32'h5A5A_A5A5),
                                       KIND_CREATED, 7'd1, '0, 1'b0));
        dir_rows.push_back(mk_cmd(CMD_UPDATE, 32'd1, 7'd0, '1, '1, 1'b1, '1));
        dir_rows.push_back(mk_cmd(CMD_DESTROY, 32'd2, '1, '0, '0, 1'b0, '0));
        // elapsed across the wrap equals the delay
        dir_rows.push_back(with_result(mk_cmd(CMD_TICK, 32'd3, '0, '0, '0, 1'b0, '0),
                                       KIND_FIRED, 7'd1, 32'h5A5A_A5A5, 1'b0));
        dir_rows.push_back(mk_cmd(CMD_UPDATE, 32'd4, 7'd1, 32'd1, '0, 1'b0, '0));
        dir_rows.push_back(mk_cmd(CMD_DESTROY, 32'd5, 7'd1, '0, '0, 1'b0, '0));
        dir_rows.push_back(mk_cmd(CMD_DESTROY, 32'd6, 7'd1, '0, '0, 1'b0, '0));
        dir_rows.push_back(mk_cmd(CMD_UPDATE, 32'd7, 7'd1, '0, '0, 1'b0, 32'd1));
        for (k = 1; k <= SLOTS; k++)
            dir_rows.push_back(with_result(mk_cmd(CMD_CREATE, 32'd1000, '0, TICK_W'(k - 1),
                                                  32'hFFFF_FFF0 + TICK_W'(k), k[0],
                                                  TICK_W'(k) * 32'h0101_0101),
                                           KIND_CREATED, SLOT_W'(k), '0, 1'b0));
        dir_rows.push_back(with_result(mk_cmd(CMD_CREATE, 32'd1001, '0, '0, '0, 1'b0, '1),
                                       KIND_FULL, 7'd0, '0, 1'b0));
        // every slot due in one sweep
        dir_rows.push_back(mk_cmd(CMD_TICK, 32'd1015, '0, '0, '0, 1'b0, '0));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) send_cmd(dir_rows[i], $urandom_range(0, 17));

        // random traffic around a slowly advancing tick count that wraps
        tick_base  = 32'hFFFF_FF00;
        accepted   = 0;
        n_items    = 0;
        burst_left = 0;
        burst      = 1'b0;
        while (accepted < 300) begin
            if (burst_left == 0) begin
                burst      = ($urandom_range(0, 3) == 0);
                burst_left = $urandom_range(8, 30);
            end
            burst_left--;

            if ($urandom_range(0, 39) == 0) tick_base = $urandom;
            else tick_base = tick_base + TICK_W'($urandom_range(0, 6));

            r = $urandom_range(0, 99);
            c = mk_cmd(CMD_TICK, tick_base, '0, '0, '0, 1'b0, $urandom);
            c.cmd = (r < 30) ? CMD_CREATE : (r < 45) ? CMD_DESTROY :
                    (r < 60) ? CMD_UPDATE : CMD_TICK;
            c.id  = ($urandom_range(0, 9) == 0) ? SLOT_W'($urandom_range(0, 127)) :
                                                  SLOT_W'($urandom_range(1, SLOTS));
            c.dly = ($urandom_range(0, 4) == 0) ? TICK_W'($urandom) :
                                                  TICK_W'($urandom_range(0, 24));
            c.ivl = ($urandom_range(0, 4) == 0) ? TICK_W'($urandom) :
                                                  TICK_W'($urandom_range(0, 24));
            c.rep = 1'($urandom_range(0, 1));

            // a slot whose repeat flag was never stored is not updated
            if (c.cmd == CMD_UPDATE && c.id != 0 && c.id <= SLOTS)
                if (!sl_written[int'(c.id) - 1]) c.cmd = CMD_TICK;

            ignored = 1'b0;
            if (c.cmd == CMD_DESTROY || c.cmd == CMD_UPDATE) begin
                if (c.id == 0 || c.id > SLOTS) ignored = 1'b1;
                else if (c.cmd == CMD_DESTROY && !sl_active[int'(c.id) - 1]) ignored = 1'b1;
            end

            // occasionally wait until every awaited result has come out
            if (n_items % 70 == 69) begin
                start <= 1'b0;
                @(posedge i_clk);
                while (awaited_events.size() != 0) @(posedge i_clk);
            end

            send_cmd(c, burst ? 0 : $urandom_range(0, 17));
            n_items++;
            if (!ignored) accepted++;
        end

        start <= 1'b0;
        while (awaited_events.size() != 0) @(posedge i_clk);
        // room for a trailing sweep and queued commands to finish
        repeat (3 * (SLOTS + 4)) @(posedge i_clk);

        if (err_cnt == 0) $display("software_timer_table_core_tb: done, clean");
        else $display("software_timer_table_core_tb: done, errors");
        $finish;
    end

endmodule
